FILE: src/bsc_pkg.sv
// Shared types and register indexes for the barometric sensor compensation block.
package bsc_pkg;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_LO  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_HI  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_P9  = 2'd3;

    localparam logic OP_TEMPERATURE = 1'b0;
    localparam logic OP_PRESSURE    = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [23:0] raw_reading;
    } t_in;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_invalid;
    } t_out;

    function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
        asr64 = 64'($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] sx16(input logic [15:0] v);
        sx16 = {{48{v[15]}}, v};
    endfunction

endpackage

FILE: src/barometric_sensor_compensation.sv
// Top level: sequenced compensation datapath with a bit-serial multiplier and divider.
//
//  channel   direction  handshake               payload
//  input     in         i_in_valid / o_in_stall  i_in_data (bsc_pkg::t_in)
//  output    out        o_out_valid / i_out_stall o_out_data (bsc_pkg::t_out)
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each 64-bit multiply retires one multiplier bit per cycle, and the signed
// division retires one quotient bit per cycle.
// Reset is synchronous, active low, and clears control state and calibration.
// One result register sits at the output; a finished item waits there while a
// new item is accepted, and the sequencer holds its result while that is full and stalled.
module barometric_sensor_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bsc_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bsc_pkg::t_out                 o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                   i_cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_T0   = 5'd1;
    localparam logic [4:0] S_T1   = 5'd2;
    localparam logic [4:0] S_T2   = 5'd3;
    localparam logic [4:0] S_T3   = 5'd4;
    localparam logic [4:0] S_P0   = 5'd5;
    localparam logic [4:0] S_P1   = 5'd6;
    localparam logic [4:0] S_P2   = 5'd7;
    localparam logic [4:0] S_P3   = 5'd8;
    localparam logic [4:0] S_P4   = 5'd9;
    localparam logic [4:0] S_P5   = 5'd10;
    localparam logic [4:0] S_P6   = 5'd11;
    localparam logic [4:0] S_P7   = 5'd12;
    localparam logic [4:0] S_P8   = 5'd13;
    localparam logic [4:0] S_P9   = 5'd14;
    localparam logic [4:0] S_P10  = 5'd15;
    localparam logic [4:0] S_P11  = 5'd16;
    localparam logic [4:0] S_MUL  = 5'd17;
    localparam logic [4:0] S_DIV  = 5'd18;
    localparam logic [4:0] S_DONE = 5'd19;

    logic [4:0]    r_state;
    logic [4:0]    r_ret;
    logic [5:0]    r_cnt;
    logic [47:0]   r_tcal;
    logic [63:0]   r_plo;
    logic [63:0]   r_phi;
    logic [15:0]   r_p9;
    logic [31:0]   r_fine;
    logic [19:0]   r_adc;
    logic [63:0]   r_v1;
    logic [63:0]   r_v1sq;
    logic [63:0]   r_v2;
    logic [63:0]   r_p;
    logic [63:0]   r_ma;
    logic [63:0]   r_mb;
    logic [63:0]   r_mp;
    logic [63:0]   r_num;
    logic [63:0]   r_rem;
    logic [63:0]   r_den;
    logic          r_qneg;
    bsc_pkg::t_out r_res;
    bsc_pkg::t_out r_out;
    logic          r_ovalid;

    logic [63:0] t1, t2, t3, d1, d2, tf, tx, ty;
    logic [63:0] pv1, pp, pnum, v1f, quo, psum;
    logic [64:0] rem2;

    always_comb begin
        t1   = {48'd0, r_tcal[15:0]};
        t2   = bsc_pkg::sx16(r_tcal[31:16]);
        t3   = bsc_pkg::sx16(r_tcal[47:32]);
        d1   = {47'd0, r_adc[19:3]} - (t1 << 1);
        d2   = {48'd0, r_adc[19:4]} - t1;
        tf   = r_v1 + bsc_pkg::asr64(r_mp, 14);
        tx   = {{32{tf[31]}}, tf[31:0]};
        ty   = bsc_pkg::asr64((tx << 2) + tx + 64'd128, 8);
        pv1  = {{32{r_fine[31]}}, r_fine} - 64'd128000;
        v1f  = bsc_pkg::asr64(r_mp, 33);
        pp   = 64'd1048576 - {44'd0, r_adc};
        pnum = (pp << 31) - r_v2;
        quo  = r_qneg ? (~r_num + 64'd1) : r_num;
        psum = bsc_pkg::asr64(r_p + r_v1 + bsc_pkg::asr64(r_mp, 19), 8)
             + (bsc_pkg::sx16(r_phi[47:32]) << 4);
        rem2 = {r_rem, r_num[63]};
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_cnt    <= '0;
            r_tcal   <= '0;
            r_plo    <= '0;
            r_phi    <= '0;
            r_p9     <= '0;
            r_fine   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bsc_pkg::CFG_TEMP_CAL: r_tcal <= i_cfg_data[47:0];
                    bsc_pkg::CFG_PRESS_LO: r_plo  <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_HI: r_phi  <= i_cfg_data;
                    bsc_pkg::CFG_PRESS_P9: r_p9   <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            // The done state handles the output register itself.
            if (r_ovalid && !i_out_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_adc   <= i_in_data.raw_reading[23:4];
                        r_state <= (i_in_data.operation == bsc_pkg::OP_PRESSURE) ? S_P0 : S_T0;
                    end
                end
                S_MUL: begin
                    if (r_mb[0]) begin
                        r_mp <= r_mp + r_ma;
                    end
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= r_ret;
                    end
                end
                S_T0: begin
                    r_ma <= d1; r_mb <= t2; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_T1; r_state <= S_MUL;
                end
                S_T1: begin
                    r_v1 <= bsc_pkg::asr64(r_mp, 11);
                    r_ma <= d2; r_mb <= d2; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_T2; r_state <= S_MUL;
                end
                S_T2: begin
                    r_ma <= bsc_pkg::asr64(r_mp, 12); r_mb <= t3; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_T3; r_state <= S_MUL;
                end
                S_T3: begin
                    r_fine <= tf[31:0];
                    r_res.result_kind       <= bsc_pkg::OP_TEMPERATURE;
                    r_res.temperature_centi <= ty[31:0];
                    r_res.pressure_q24_8    <= '0;
                    r_res.pressure_invalid  <= 1'b0;
                    r_state <= S_DONE;
                end
                S_P0: begin
                    r_v1 <= pv1;
                    r_ma <= pv1; r_mb <= pv1; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P1; r_state <= S_MUL;
                end
                S_P1: begin
                    r_v1sq <= r_mp;
                    r_ma <= r_mp; r_mb <= bsc_pkg::sx16(r_phi[31:16]); r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P2; r_state <= S_MUL;
                end
                S_P2: begin
                    r_v2 <= r_mp;
                    r_ma <= r_v1; r_mb <= bsc_pkg::sx16(r_phi[15:0]); r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P3; r_state <= S_MUL;
                end
                S_P3: begin
                    r_v2 <= r_v2 + (r_mp << 17) + (bsc_pkg::sx16(r_plo[63:48]) << 35);
                    r_ma <= r_v1sq; r_mb <= bsc_pkg::sx16(r_plo[47:32]); r_mp <= '0;
                    r_cnt <= '0; r_ret <= S_P4; r_state <= S_MUL;
                end
                S_P4: begin
                    r_v1sq <= bsc_pkg::asr64(r_mp, 8);
                    r_ma <= r_v1; r_mb <= bsc_pkg::sx16(r_plo[31:16]); r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P5; r_state <= S_MUL;
                end
                S_P5: begin
                    r_ma <= (64'd1 << 47) + r_v1sq + (r_mp << 12);
                    r_mb <= {48'd0, r_plo[15:0]}; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P6; r_state <= S_MUL;
                end
                S_P6: begin
                    if (v1f == '0) begin
                        r_res.result_kind       <= bsc_pkg::OP_PRESSURE;
                        r_res.temperature_centi <= '0;
                        r_res.pressure_q24_8    <= '0;
                        r_res.pressure_invalid  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_v1 <= v1f;
                        r_ma <= pnum; r_mb <= 64'd3125; r_mp <= '0; r_cnt <= '0;
                        r_ret <= S_P7; r_state <= S_MUL;
                    end
                end
                S_P7: begin
                    // Divide magnitudes, fix the sign of the quotient afterwards.
                    r_num  <= r_mp[63] ? (~r_mp + 64'd1) : r_mp;
                    r_den  <= r_v1[63] ? (~r_v1 + 64'd1) : r_v1;
                    r_qneg <= r_mp[63] ^ r_v1[63];
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (rem2 >= {1'b0, r_den}) begin
                        r_rem <= 64'(rem2 - {1'b0, r_den});
                        r_num <= {r_num[62:0], 1'b1};
                    end else begin
                        r_rem <= rem2[63:0];
                        r_num <= {r_num[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_state <= S_P8;
                    end
                end
                S_P8: begin
                    r_p  <= quo;
                    r_ma <= bsc_pkg::sx16(r_p9); r_mb <= bsc_pkg::asr64(quo, 13);
                    r_mp <= '0; r_cnt <= '0; r_ret <= S_P9; r_state <= S_MUL;
                end
                S_P9: begin
                    r_ma <= r_mp; r_mb <= bsc_pkg::asr64(r_p, 13); r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P10; r_state <= S_MUL;
                end
                S_P10: begin
                    r_v1 <= bsc_pkg::asr64(r_mp, 25);
                    r_ma <= bsc_pkg::sx16(r_phi[63:48]); r_mb <= r_p; r_mp <= '0; r_cnt <= '0;
                    r_ret <= S_P11; r_state <= S_MUL;
                end
                S_P11: begin
                    r_res.result_kind       <= bsc_pkg::OP_PRESSURE;
                    r_res.temperature_centi <= '0;
                    r_res.pressure_invalid  <= 1'b0;
                    if (psum[63]) begin
                        r_res.pressure_q24_8 <= '0;
                    end else if (|psum[62:32]) begin
                        r_res.pressure_q24_8 <= '1;
                    end else begin
                        r_res.pressure_q24_8 <= psum[31:0];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_out_stall) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: src/bsc_checker.sv
// Port-level checker for the compensation block, bound to its top level.
module bsc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input bsc_pkg::t_out o_out_data
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output transfer changed");

    a_temp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.result_kind |->
            o_out_data.pressure_q24_8 == '0 && !o_out_data.pressure_invalid)
        else $error("temperature result carries pressure fields");

    a_press_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.result_kind |-> o_out_data.temperature_centi == '0)
        else $error("pressure result carries a temperature");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.pressure_invalid |->
            o_out_data.result_kind && o_out_data.pressure_q24_8 == '0)
        else $error("invalid pressure result is not zero");

endmodule

bind barometric_sensor_compensation bsc_checker u_bsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
